>>> sv/ceiling_texture_coordinate_stepper_defines.svh
// ----------------------------------------------------------------------------
// Ceiling texture coordinate stepper assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CEILING_TEXTURE_COORDINATE_STEPPER_DEFINES_SVH
`define CEILING_TEXTURE_COORDINATE_STEPPER_DEFINES_SVH

// Assertion sampled on the rising clock edge and switched off while in reset.
`define CTCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define CTCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/ctcs_pkg.sv
// ----------------------------------------------------------------------------
// Ceiling texture coordinate stepper package
// Types, constants and helper functions shared by the stepper modules.
// ----------------------------------------------------------------------------
package ctcs_pkg;

  // Screen and texture geometry. The screen width is an odd factor times a
  // power of two, so the step division splits into a shift and a reciprocal.
  localparam int unsigned ScreenWOdd  = 5;
  localparam int unsigned ScreenWPow2 = 7;
  localparam int unsigned ScreenW     = ScreenWOdd << ScreenWPow2;
  localparam int unsigned TexWLog2    = 6;
  localparam int unsigned TexHLog2    = 6;

  // Field widths.
  localparam int unsigned ColW     = 10;
  localparam int unsigned RowW     = 10;
  localparam int unsigned TexelW   = 6;
  localparam int unsigned FocalW   = 20;
  localparam int unsigned RayW     = 16;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned FocalFrW = 8;
  localparam int unsigned RayFracW = 14;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Row distance is (focal << 8) / p, so it needs the focal width plus eight bits.
  localparam int unsigned DistW    = FocalW + FocalFrW;
  // Product of the row distance and a ray magnitude.
  localparam int unsigned ProdW    = DistW + RayW;
  localparam int unsigned DivCntW  = $clog2(DistW + 1);

  // The step divides by the screen width in ray fraction units: the power of
  // two is dropped by a shift, the odd factor by a reciprocal multiplication
  // that is exact for every shifted product.
  localparam int unsigned StepShift  = ScreenWPow2 + RayFracW;
  localparam int unsigned StepHiW    = ProdW - StepShift;
  localparam int unsigned RecipShift = StepHiW + 2;
  localparam logic [StepHiW-1:0] StepRecip =
    StepHiW'(((64'd1 << RecipShift) + 64'(ScreenWOdd) - 64'd1) / 64'(ScreenWOdd));

  // Register reset values.
  localparam logic [RowW-1:0]   HorizonRst = 10'd240;
  localparam logic [FocalW-1:0] FocalRst   = 20'd141891;
  localparam logic [RayW-1:0]   LeftXRst   = 16'd14189;
  localparam logic [RayW-1:0]   LeftYRst   = 16'hE000;
  localparam logic [RayW-1:0]   RightXRst  = 16'd14189;
  localparam logic [RayW-1:0]   RightYRst  = 16'd8192;

  // Configuration register indices.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HORIZON_ROW    = 3'd0,
    CFG_FOCAL_DISTANCE = 3'd1,
    CFG_PLAYER_POS_X   = 3'd2,
    CFG_PLAYER_POS_Y   = 3'd3,
    CFG_LEFT_RAY_X     = 3'd4,
    CFG_LEFT_RAY_Y     = 3'd5,
    CFG_RIGHT_RAY_X    = 3'd6,
    CFG_RIGHT_RAY_Y    = 3'd7
  } cfg_index_e;

  // Input item.
  typedef struct packed {
    logic [ColW-1:0] pixel_column;
    logic [RowW-1:0] pixel_row;
  } pixel_t;

  // Result item.
  typedef struct packed {
    logic [ColW-1:0]   out_column;
    logic [RowW-1:0]   out_row;
    logic [TexelW-1:0] texel_x;
    logic [TexelW-1:0] texel_y;
    logic              texel_valid;
  } texel_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_MUL_LX,
    ST_MUL_LY,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_STEP_Y,
    ST_EMIT
  } ctcs_state_e;

  // Multiplier operand choice.
  typedef enum logic [1:0] {
    MUL_LEFT_X,
    MUL_LEFT_Y,
    MUL_DELTA_X,
    MUL_DELTA_Y
  } mul_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     emit_direct;
    logic     emit_item;
    logic     div_start;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     dist_load;
    logic     world_x_load;
    logic     world_y_load;
    logic     step_x_load;
    logic     step_y_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_setup;
    logic div_busy;
  } dp_status_t;

  // Texel index of a Q16.16 coordinate: saturated magnitude, scaled by the
  // power-of-two texture size, wrapped to that size.
  function automatic logic [TexelW-1:0] texel_of(input logic [CoordW-1:0] coord,
                                                 input int unsigned size_log2);
    logic [CoordW-1:0] mag;
    logic [CoordW-1:0] idx;
    logic [CoordW-1:0] mask;
    mag = coord[CoordW-1] ? (~coord + 1'b1) : coord;
    if (mag[CoordW-1]) begin
      mag = {1'b0, {(CoordW-1){1'b1}}};
    end
    idx  = mag >> (FracW - size_log2);
    mask = (CoordW'(1) << size_log2) - 1'b1;
    return TexelW'(idx & mask);
  endfunction

endpackage

>>> sv/ceiling_texture_coordinate_stepper.sv
// ----------------------------------------------------------------------------
// Ceiling texture coordinate stepper
// Maps ceiling scanline pixels to texel coordinates by floor casting.
// ----------------------------------------------------------------------------
// A pixel at a non-zero column, or on a row at or below the horizon, is
// transferred straight into the output register, so such pixels stream at one
// per clock while the consumer keeps up. A pixel at column 0 of a row above the
// horizon starts the row set-up on its transfer, before its result appears: the
// restoring divider forms the row distance at one quotient bit per cycle, the
// distance is loaded, the shared multiplier forms the two start offsets and the
// two span products in turn, the division of a span by the screen width is a
// shift and a reciprocal multiply inside the step load, and the y step load and
// the result load follow. No further input is taken during set-up. Configuration
// writes are taken in every cycle and must only be made while the block is idle.
module ceiling_texture_coordinate_stepper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ctcs_pkg::pixel_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ctcs_pkg::texel_t              out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ctcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ctcs_pkg::CfgDataW-1:0] cfg_data_i
);
  import ctcs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration transfers are always accepted.
  assign cfg_ready_o = 1'b1;

  // Controller.
  ctcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  ctcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_write_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sv/ctcs_divider.sv
// ----------------------------------------------------------------------------
// Ceiling texture coordinate stepper divider
// Restoring divider that retires one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module ctcs_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ctcs_pkg::DistW-1:0]  dividend_i,
  input  logic [ctcs_pkg::RowW-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [ctcs_pkg::DistW-1:0]  quotient_o
);
  import ctcs_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DistW-1:0]   quo_q;
  logic [RowW-1:0]    rem_q;
  logic [RowW-1:0]    dvs_q;
  logic [RowW:0]      rem_sh;
  logic [RowW:0]      rem_sub;
  logic               fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh  = {rem_q, quo_q[DistW-1]};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Iteration count and busy flag.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DistW);
    end else if (busy_q) begin
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[RowW-1:0] : rem_sh[RowW-1:0];
      quo_q <= {quo_q[DistW-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> sv/ctcs_ctrl.sv
// ----------------------------------------------------------------------------
// Ceiling texture coordinate stepper controller
// Handshake control and the row set-up sequence state machine.
// ----------------------------------------------------------------------------
module ctcs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ctcs_pkg::dp_status_t   status_i,
  output ctcs_pkg::ctrl_cmd_t    cmd_o
);
  import ctcs_pkg::*;

  ctcs_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  logic        emit;

  // The output register can take a result when empty or being emptied.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{
      load_item:    1'b0,
      emit_direct:  1'b0,
      emit_item:    1'b0,
      div_start:    1'b0,
      mul_en:       1'b0,
      mul_sel:      MUL_LEFT_X,
      dist_load:    1'b0,
      world_x_load: 1'b0,
      world_y_load: 1'b0,
      step_x_load:  1'b0,
      step_y_load:  1'b0
    };
    case (state_q)
      ST_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          if (status_i.needs_setup) begin
            cmd_o.load_item = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIST;
          end else begin
            cmd_o.emit_direct = 1'b1;
          end
        end
      end
      ST_DIST: begin
        if (!status_i.div_busy) begin
          cmd_o.dist_load = 1'b1;
          state_d         = ST_MUL_LX;
        end
      end
      ST_MUL_LX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LEFT_X;
        state_d       = ST_MUL_LY;
      end
      ST_MUL_LY: begin
        cmd_o.mul_en       = 1'b1;
        cmd_o.mul_sel      = MUL_LEFT_Y;
        cmd_o.world_x_load = 1'b1;
        state_d            = ST_MUL_DX;
      end
      ST_MUL_DX: begin
        cmd_o.mul_en       = 1'b1;
        cmd_o.mul_sel      = MUL_DELTA_X;
        cmd_o.world_y_load = 1'b1;
        state_d            = ST_MUL_DY;
      end
      ST_MUL_DY: begin
        // The x span product is ready: take its step while the y span is formed.
        cmd_o.mul_en      = 1'b1;
        cmd_o.mul_sel     = MUL_DELTA_Y;
        cmd_o.step_x_load = 1'b1;
        state_d           = ST_STEP_Y;
      end
      ST_STEP_Y: begin
        cmd_o.step_y_load = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit_item = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  assign emit = cmd_o.emit_direct || cmd_o.emit_item;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/ctcs_datapath.sv
// ----------------------------------------------------------------------------
// Ceiling texture coordinate stepper datapath
// Configuration registers, row set-up arithmetic, world point and texels.
// ----------------------------------------------------------------------------
module ctcs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctcs_pkg::ctrl_cmd_t           cmd_i,
  output ctcs_pkg::dp_status_t          status_o,
  input  logic                          cfg_write_i,
  input  logic [ctcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ctcs_pkg::CfgDataW-1:0] cfg_data_i,
  input  ctcs_pkg::pixel_t              in_data_i,
  output ctcs_pkg::texel_t              out_data_o
);
  import ctcs_pkg::*;

  // Configuration registers.
  logic [RowW-1:0]   horizon_q;
  logic [FocalW-1:0] focal_q;
  logic [CoordW-1:0] pos_x_q, pos_y_q;
  logic [RayW-1:0]   left_x_q, left_y_q, right_x_q, right_y_q;

  // Working registers.
  pixel_t            item_q;
  logic [DistW-1:0]  dist_q;
  logic [ProdW-1:0]  prod_q;
  logic              prod_neg_q;
  logic [CoordW-1:0] world_x_q, world_x_d;
  logic [CoordW-1:0] world_y_q, world_y_d;
  logic [CoordW-1:0] step_x_q, step_x_d;
  logic [CoordW-1:0] step_y_q, step_y_d;
  texel_t            out_q;

  // Configuration writes; every index names a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= HorizonRst;
      focal_q   <= FocalRst;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      left_x_q  <= LeftXRst;
      left_y_q  <= LeftYRst;
      right_x_q <= RightXRst;
      right_y_q <= RightYRst;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CFG_HORIZON_ROW:    horizon_q <= cfg_data_i[RowW-1:0];
        CFG_FOCAL_DISTANCE: focal_q   <= cfg_data_i[FocalW-1:0];
        CFG_PLAYER_POS_X:   pos_x_q   <= cfg_data_i[CoordW-1:0];
        CFG_PLAYER_POS_Y:   pos_y_q   <= cfg_data_i[CoordW-1:0];
        CFG_LEFT_RAY_X:     left_x_q  <= cfg_data_i[RayW-1:0];
        CFG_LEFT_RAY_Y:     left_y_q  <= cfg_data_i[RayW-1:0];
        CFG_RIGHT_RAY_X:    right_x_q <= cfg_data_i[RayW-1:0];
        CFG_RIGHT_RAY_Y:    right_y_q <= cfg_data_i[RayW-1:0];
        default: ;
      endcase
    end
  end

  // Row test on the incoming item.
  logic in_above;
  assign in_above = (in_data_i.pixel_row < horizon_q);
  assign status_o.needs_setup = in_above && (in_data_i.pixel_column == '0);

  // Row distance divider.
  logic              div_busy;
  logic [DistW-1:0]  div_quot;
  logic [DistW-1:0]  div_dividend;
  logic [RowW-1:0]   row_gap;

  assign row_gap      = horizon_q - in_data_i.pixel_row;
  assign div_dividend = {focal_q, {FocalFrW{1'b0}}};

  ctcs_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (row_gap),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  assign status_o.div_busy = div_busy;

  // Multiplier operand: a ray or the ray span, split into sign and magnitude.
  logic [RayW:0]   left_x_ext, left_y_ext, delta_x, delta_y;
  logic [RayW:0]   ray_sel, ray_abs;
  logic            ray_neg;
  logic [RayW-1:0] ray_mag;
  logic [ProdW-1:0] prod_d;

  assign left_x_ext = {left_x_q[RayW-1], left_x_q};
  assign left_y_ext = {left_y_q[RayW-1], left_y_q};
  assign delta_x    = {right_x_q[RayW-1], right_x_q} - left_x_ext;
  assign delta_y    = {right_y_q[RayW-1], right_y_q} - left_y_ext;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LEFT_X:  ray_sel = left_x_ext;
      MUL_LEFT_Y:  ray_sel = left_y_ext;
      MUL_DELTA_X: ray_sel = delta_x;
      MUL_DELTA_Y: ray_sel = delta_y;
      default:     ray_sel = left_x_ext;
    endcase
    ray_neg = ray_sel[RayW];
    ray_abs = ray_neg ? (~ray_sel + 1'b1) : ray_sel;
    ray_mag = ray_abs[RayW-1:0];
    prod_d  = ProdW'(dist_q) * ProdW'(ray_mag);
  end

  // Start offset: product shifted from Q.30 to Q.16, truncated toward zero.
  logic [CoordW-1:0] off_mag, off_val;
  assign off_mag = CoordW'(prod_q[ProdW-1:RayFracW]);
  assign off_val = prod_neg_q ? (~off_mag + 1'b1) : off_mag;

  // Step: span product over the screen width, truncated toward zero, sign
  // restored. The power of two goes by a shift, the odd factor by a
  // reciprocal multiplication.
  logic [StepHiW-1:0]   step_hi;
  logic [2*StepHiW-1:0] step_scaled;
  logic [CoordW-1:0]    quot_mag, quot_val;
  assign step_hi     = prod_q[ProdW-1:StepShift];
  assign step_scaled = (2*StepHiW)'(step_hi) * (2*StepHiW)'(StepRecip);
  assign quot_mag    = CoordW'(step_scaled[2*StepHiW-1:RecipShift]);
  assign quot_val    = prod_neg_q ? (~quot_mag + 1'b1) : quot_mag;

  // Result for the item being emitted.
  pixel_t            src;
  logic              src_above;
  logic              emit;

  assign src       = cmd_i.emit_item ? item_q : in_data_i;
  assign src_above = (src.pixel_row < horizon_q);
  assign emit      = cmd_i.emit_direct || cmd_i.emit_item;

  // World point and step updates: stepping wins over set-up loads.
  always_comb begin
    world_x_d = world_x_q;
    world_y_d = world_y_q;
    step_x_d  = step_x_q;
    step_y_d  = step_y_q;
    if (cmd_i.world_x_load) begin
      world_x_d = pos_x_q + off_val;
    end
    if (cmd_i.world_y_load) begin
      world_y_d = pos_y_q + off_val;
    end
    if (cmd_i.step_x_load) begin
      step_x_d = quot_val;
    end
    if (cmd_i.step_y_load) begin
      step_y_d = quot_val;
    end
    if (emit && src_above) begin
      world_x_d = world_x_q + step_x_q;
      world_y_d = world_y_q + step_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_x_q <= '0;
      world_y_q <= '0;
      step_x_q  <= '0;
      step_y_q  <= '0;
    end else begin
      world_x_q <= world_x_d;
      world_y_q <= world_y_d;
      step_x_q  <= step_x_d;
      step_y_q  <= step_y_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.dist_load) begin
      dist_q <= div_quot;
    end
    if (cmd_i.mul_en) begin
      prod_q     <= prod_d;
      prod_neg_q <= ray_neg;
    end
    if (emit) begin
      out_q.out_column  <= src.pixel_column;
      out_q.out_row     <= src.pixel_row;
      out_q.texel_x     <= src_above ? texel_of(world_x_q, TexWLog2) : '0;
      out_q.texel_y     <= src_above ? texel_of(world_y_q, TexHLog2) : '0;
      out_q.texel_valid <= src_above;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> sv/ctcs_checker.sv
// ----------------------------------------------------------------------------
// Ceiling texture coordinate stepper port checker
// Assertions on the top level ports, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "ceiling_texture_coordinate_stepper_defines.svh"

module ctcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input ctcs_pkg::pixel_t              in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input ctcs_pkg::texel_t              out_data_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [ctcs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [ctcs_pkg::CfgDataW-1:0] cfg_data_i
);
  import ctcs_pkg::*;

  // No result is offered while in reset.
  `CTCS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result offered during reset")

  // A stalled result is held until its transfer.
  `CTCS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // A pixel past column zero gives its result in the very next cycle.
  `CTCS_ASSERT(a_col_direct, in_valid_i && in_ready_o && in_data_i.pixel_column != '0 |=> out_valid_o && out_data_o.out_column == $past(in_data_i.pixel_column) && out_data_o.out_row == $past(in_data_i.pixel_row), "non-zero column not passed straight through")

  // Rows at or below the horizon carry zero texels.
  `CTCS_ASSERT(a_invalid_zero, out_valid_o && !out_data_o.texel_valid |-> out_data_o.texel_x == '0 && out_data_o.texel_y == '0, "invalid row with non-zero texel")

endmodule

bind ceiling_texture_coordinate_stepper ctcs_checker u_ctcs_checker (.*);

>>> verif/ceiling_texture_coordinate_stepper_tb.sv
// ----------------------------------------------------------------------------
// Ceiling texture coordinate stepper testbench
// Streams ceiling scanline pixels through the stepper under bursty input and
// a stalling consumer, predicts every texel with an independent fixed-point
// model of the floor casting arithmetic, and checks each result transfer in
// order. A short scripted part covers reset state, the horizon and the
// extremes of every register; random register settings and scanlines follow.
// ----------------------------------------------------------------------------
module ceiling_texture_coordinate_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctcs_pkg::*;

  // Geometry and arithmetic of the prediction.
  localparam longint COLUMN_SPAN  = 640 * 16384;
  localparam longint TEXTURE_SIZE = 64;
  localparam int     FRAC_BITS    = 16;
  localparam int     RAY_FRAC     = 14;
  localparam int     NUM_PHASES   = 8;
  localparam int     PHASE_ITEMS  = 182;
  localparam int     DRAIN_CYCLES = 150;
  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     MAX_REPORTS  = 10;

  typedef enum logic {
    DIR_WRITE,
    DIR_PIXEL
  } script_kind_e;

  // One line of the scripted opening: a register write or a pixel, with a
  // hand-worked texel where the answer is obvious.
  typedef struct {
    script_kind_e kind;
    cfg_index_e   reg_idx;
    logic [31:0]  reg_val;
    pixel_t       pix;
    bit           known;
    texel_t       result;
  } script_line_t;

  // Block ports.
  logic                clk_i       = 1'b0;
  logic                rst_ni;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  pixel_t              in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  texel_t              out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_HORIZON_ROW;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Hand-worked texel travelling alongside the pixel on the input channel.
  bit     known_flag   = 1'b0;
  texel_t known_result = '0;

  // Register copies and casting state of the prediction.
  logic [9:0]         m_horizon;
  logic [19:0]        m_focal;
  logic [31:0]        m_pos_x;
  logic [31:0]        m_pos_y;
  logic signed [15:0] m_lray_x;
  logic signed [15:0] m_lray_y;
  logic signed [15:0] m_rray_x;
  logic signed [15:0] m_rray_y;
  logic [31:0]        walk_x;
  logic [31:0]        walk_y;
  logic [31:0]        stride_x;
  logic [31:0]        stride_y;

  texel_t       expected_texels[$];
  script_line_t script[$];

  // Sender and receiver pacing.
  int unsigned burst_left    = 0;
  bit          steady_sender = 1'b0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  stall_phase;

  // Run statistics.
  int unsigned pixels_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned row_setups     = 0;
  int unsigned below_horizon  = 0;
  int unsigned settings_count = 0;
  int unsigned faults         = 0;
  int unsigned cycle_count    = 0;

  ceiling_texture_coordinate_stepper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Signed Q.30 product brought to Q.16, rounding toward zero.
  function automatic longint drop_ray_frac(input longint prod);
    return (prod < 0) ? -((-prod) >>> RAY_FRAC) : (prod >>> RAY_FRAC);
  endfunction

  // Texel of a Q16.16 coordinate from its saturated magnitude.
  function automatic logic [5:0] texel_index(input logic [31:0] coord);
    logic [31:0] mag;
    longint      scaled;
    mag = coord[31] ? (~coord + 32'd1) : coord;
    if (mag > 32'h7FFF_FFFF) begin
      mag = 32'h7FFF_FFFF;
    end
    scaled = (longint'(mag) * TEXTURE_SIZE) >>> FRAC_BITS;
    return 6'(scaled % TEXTURE_SIZE);
  endfunction

  // Texel shown at one pixel; a column 0 pixel above the horizon first sets
  // up the start point and per-column step of its row.
  function automatic texel_t predict_texel(input pixel_t pix);
    texel_t      t;
    logic [9:0]  span;
    logic [27:0] dist_u;
    longint      row_dist;
    longint      lx;
    longint      ly;
    longint      dx;
    longint      dy;
    t             = '0;
    t.out_column  = pix.pixel_column;
    t.out_row     = pix.pixel_row;
    t.texel_valid = pix.pixel_row < m_horizon;
    if (!t.texel_valid) begin
      return t;
    end
    if (pix.pixel_column == '0) begin
      span     = m_horizon - pix.pixel_row;
      dist_u   = {m_focal, 8'h00} / span;
      row_dist = longint'(dist_u);
      lx       = m_lray_x;
      ly       = m_lray_y;
      dx       = longint'(m_rray_x) - lx;
      dy       = longint'(m_rray_y) - ly;
      walk_x   = m_pos_x + 32'(drop_ray_frac(row_dist * lx));
      walk_y   = m_pos_y + 32'(drop_ray_frac(row_dist * ly));
      stride_x = 32'((row_dist * dx) / COLUMN_SPAN);
      stride_y = 32'((row_dist * dy) / COLUMN_SPAN);
    end
    t.texel_x = texel_index(walk_x);
    t.texel_y = texel_index(walk_y);
    walk_x    = walk_x + stride_x;
    walk_y    = walk_y + stride_y;
    return t;
  endfunction

  // Compares one result transfer with the oldest pending texel.
  function automatic void check_texel(input texel_t got);
    texel_t want;
    if (expected_texels.size() == 0) begin
      faults++;
      if (faults <= MAX_REPORTS) begin
        $display("Unexpected texel at col %0d row %0d: no pixel pending",
                 got.out_column, got.out_row);
      end
      return;
    end
    want = expected_texels.pop_front();
    if (got.out_column !== want.out_column || got.out_row !== want.out_row ||
        got.texel_x !== want.texel_x || got.texel_y !== want.texel_y ||
        got.texel_valid !== want.texel_valid) begin
      faults++;
      if (faults <= MAX_REPORTS) begin
        $display("Texel mismatch: expected col %0d row %0d x %0d y %0d valid %0d",
                 want.out_column, want.out_row, want.texel_x, want.texel_y,
                 want.texel_valid);
        $display("                got      col %0d row %0d x %0d y %0d valid %0d",
                 got.out_column, got.out_row, got.texel_x, got.texel_y,
                 got.texel_valid);
      end
    end
  endfunction

  // Pixel transfers are predicted as they are taken, results checked in order.
  always @(posedge clk_i) begin : monitor
    texel_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (in_data_i.pixel_row >= m_horizon) begin
          below_horizon++;
        end else if (in_data_i.pixel_column == '0) begin
          row_setups++;
        end
        want = predict_texel(in_data_i);
        expected_texels.push_back(known_flag ? known_result : want);
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        check_texel(out_data_o);
      end
    end
  end

  // The consumer stalls according to a rotating pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= '0;
    end else begin
      out_ready_i <= ready_pattern[stall_phase];
      stall_phase <= stall_phase + 4'd1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d texels outstanding",
               cycle_count, expected_texels.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one pixel; when a burst has run out, a new one starts, often after an idle gap.
  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row,
                            input bit known = 1'b0, input texel_t result = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = (steady_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i             <= 1'b1;
    in_data_i.pixel_column <= col;
    in_data_i.pixel_row    <= row;
    known_flag             <= known;
    known_result           <= result;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
  endtask

  // Stops offering pixels and waits until every texel has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (expected_texels.size() != 0);
    @(posedge clk_i);
  endtask

  // One register write transfer; the caller lowers the valid afterwards.
  task automatic write_reg(input cfg_index_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_HORIZON_ROW:    m_horizon = val[9:0];
      CFG_FOCAL_DISTANCE: m_focal   = val[19:0];
      CFG_PLAYER_POS_X:   m_pos_x   = val;
      CFG_PLAYER_POS_Y:   m_pos_y   = val;
      CFG_LEFT_RAY_X:     m_lray_x  = val[15:0];
      CFG_LEFT_RAY_Y:     m_lray_y  = val[15:0];
      CFG_RIGHT_RAY_X:    m_rray_x  = val[15:0];
      CFG_RIGHT_RAY_Y:    m_rray_y  = val[15:0];
      default: ;
    endcase
  endtask

  // Consecutive columns of one row, stopping at the widest column code.
  task automatic run_scanline(input int row, input int first, input int len);
    for (int c = first; c < first + len && c <= 1023; c++) begin
      send_pixel(10'(c), 10'(row));
    end
  endtask

  function automatic logic [31:0] pick_ray();
    case ($urandom_range(0, 5))
      0:       return -32'sd16384;
      1:       return 32'd16384;
      default: return $urandom_range(0, 32768) - 16384;
    endcase
  endfunction

  // Mostly rows across the whole sky, with the row just above the horizon
  // and the top row favoured.
  function automatic int pick_sky_row();
    case ($urandom_range(0, 9))
      0:       return m_horizon - 1;
      1:       return 0;
      default: return $urandom_range(0, m_horizon - 1);
    endcase
  endfunction

  // Fresh register settings and pacing for one random phase; the first two
  // phases take the upper and lower extremes throughout.
  task automatic configure_phase(input int phase);
    logic [31:0] vals [8];
    if (phase == 0) begin
      vals = '{32'd1023, 32'hFFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'd16384, 32'd16384, 32'd16384, 32'd16384};
    end else if (phase == 1) begin
      vals = '{32'd1, 32'd1, 32'h8000_0000, 32'h8000_0000,
               -32'sd16384, -32'sd16384, -32'sd16384, -32'sd16384};
    end else begin
      vals[0] = ($urandom_range(0, 4) == 0) ? 32'd1023 : $urandom_range(1, 1023);
      vals[1] = ($urandom_range(0, 4) == 0) ? 32'hFFFFF : $urandom_range(0, 20'hFFFFF);
      vals[2] = $urandom();
      vals[3] = $urandom();
      for (int i = 4; i < 8; i++) begin
        vals[i] = pick_ray();
      end
    end
    for (int i = 0; i < 8; i++) begin
      write_reg(cfg_index_e'(i), vals[i]);
    end
    cfg_valid_i   <= 1'b0;
    steady_sender = (phase % 3 == 0);
    ready_pattern <= (phase % 4 == 1) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    settings_count++;
  endtask

  function automatic void add_write(input cfg_index_e idx, input logic [31:0] val);
    script_line_t s;
    s         = '{default: '0, kind: DIR_WRITE, reg_idx: CFG_HORIZON_ROW};
    s.reg_idx = idx;
    s.reg_val = val;
    script.push_back(s);
  endfunction

  function automatic void add_pixel(input int col, input int row);
    script_line_t s;
    s     = '{default: '0, kind: DIR_PIXEL, reg_idx: CFG_HORIZON_ROW};
    s.pix = '{pixel_column: 10'(col), pixel_row: 10'(row)};
    script.push_back(s);
  endfunction

  function automatic void add_known(input int col, input int row, input int tx,
                                    input int ty, input bit valid);
    script_line_t s;
    s        = '{default: '0, kind: DIR_PIXEL, reg_idx: CFG_HORIZON_ROW};
    s.pix    = '{pixel_column: 10'(col), pixel_row: 10'(row)};
    s.known  = 1'b1;
    s.result = '{out_column: 10'(col), out_row: 10'(row), texel_x: 6'(tx),
                 texel_y: 6'(ty), texel_valid: valid};
    script.push_back(s);
  endfunction

  initial begin
    bit          after_pixel;
    int unsigned pick;
    int unsigned target;

    // Reset is driven low at the start so that its falling edge clears the block.
    rst_ni <= 1'b0;

    // Power-on register values and cleared casting state.
    m_horizon = HorizonRst;
    m_focal   = FocalRst;
    m_pos_x   = '0;
    m_pos_y   = '0;
    m_lray_x  = LeftXRst;
    m_lray_y  = LeftYRst;
    m_rray_x  = RightXRst;
    m_rray_y  = RightYRst;
    walk_x    = '0;
    walk_y    = '0;
    stride_x  = '0;
    stride_y  = '0;

    // Power-on settings: nothing set up yet, so the world point sits at the
    // origin; rows at or below the horizon give blank texels.
    add_known(5, 10, 0, 0, 1);
    add_known(0, 1023, 0, 0, 0);
    add_known(0, 240, 0, 0, 0);
    add_known(1023, 239, 0, 0, 1);
    add_pixel(0, 239);
    add_pixel(1, 239);
    add_pixel(2, 0);
    add_pixel(0, 0);
    add_pixel(639, 0);
    // Upper and lower extremes of every register at once.
    add_write(CFG_HORIZON_ROW, 32'd1023);
    add_write(CFG_FOCAL_DISTANCE, 32'hFFFFF);
    add_write(CFG_PLAYER_POS_X, 32'h7FFF_FFFF);
    add_write(CFG_PLAYER_POS_Y, 32'h8000_0000);
    add_write(CFG_LEFT_RAY_X, -32'sd16384);
    add_write(CFG_LEFT_RAY_Y, 32'd16384);
    add_write(CFG_RIGHT_RAY_X, 32'd16384);
    add_write(CFG_RIGHT_RAY_Y, -32'sd16384);
    add_pixel(0, 1022);
    add_pixel(1, 1022);
    add_pixel(2, 1022);
    add_pixel(0, 0);
    add_pixel(1, 0);
    add_known(0, 1023, 0, 0, 0);
    // Horizon on the top row: the whole screen is floor.
    add_write(CFG_HORIZON_ROW, 32'd0);
    add_known(0, 0, 0, 0, 0);
    add_known(700, 1023, 0, 0, 0);
    // Zero focal distance pins the point to the player; the most negative
    // position saturates its magnitude, so both texels read the top code.
    add_write(CFG_HORIZON_ROW, 32'd1023);
    add_write(CFG_FOCAL_DISTANCE, 32'd0);
    add_write(CFG_PLAYER_POS_X, 32'h8000_0000);
    add_write(CFG_PLAYER_POS_Y, 32'h7FFF_FFFF);
    add_known(0, 500, 63, 63, 1);
    add_known(1, 500, 63, 63, 1);
    // Largest step, wrapping past the positive end of the map.
    add_write(CFG_FOCAL_DISTANCE, 32'hFFFFF);
    add_pixel(0, 1022);
    add_pixel(1, 1022);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted opening.
    after_pixel = 1'b1;
    foreach (script[i]) begin
      if (script[i].kind == DIR_WRITE) begin
        if (after_pixel) begin
          wait_idle();
          settings_count++;
        end
        write_reg(script[i].reg_idx, script[i].reg_val);
        after_pixel = 1'b0;
      end else begin
        cfg_valid_i <= 1'b0;
        send_pixel(script[i].pix.pixel_column, script[i].pix.pixel_row,
                   script[i].known, script[i].result);
        after_pixel = 1'b1;
      end
    end

    // Random phases: mostly scanline runs from column 0, with floor rows,
    // stray pixels and rows picked up part way along as noise.
    target = pixels_sent;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      configure_phase(ph);
      target += PHASE_ITEMS;
      while (pixels_sent < target) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          run_scanline(pick_sky_row(), 0,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 24));
        end else if (pick == 7) begin
          run_scanline($urandom_range(m_horizon, 1023), 0, $urandom_range(1, 6));
        end else if (pick == 8) begin
          send_pixel(10'($urandom()), 10'($urandom()));
        end else begin
          run_scanline(pick_sky_row(), $urandom_range(1, 1023), $urandom_range(1, 10));
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_texels.size() != 0) begin
      faults++;
      $display("%0d texels never arrived", expected_texels.size());
    end

    $display("Sent %0d pixels under %0d register settings: %0d row set-ups, %0d floor pixels.",
             pixels_sent, settings_count, row_setups, below_horizon);
    $display("Checked %0d texels in %0d cycles, %0d faults.",
             results_seen, cycle_count, faults);
    if (faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
